[sv/lplf_pkg.sv]
`timescale 1ns / 1ps

package lplf_pkg;

    localparam int PATTERN_LEDS  = 3;
    localparam int CH_PER_LED    = 3;
    localparam int CHANNELS      = PATTERN_LEDS * CH_PER_LED;
    localparam int CH_IDX_W      = $clog2(CHANNELS);
    localparam int BYTE_W        = 8;
    localparam int FRACTION_BITS = 16;
    localparam int LVL_W         = BYTE_W + FRACTION_BITS;
    localparam int INC_W         = LVL_W + 1;
    localparam int SUM_W         = LVL_W + 2;
    localparam int COLOR_W       = CH_PER_LED * BYTE_W;
    localparam int FC_W          = 16;
    localparam int DIV_STEPS     = LVL_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = COLOR_W;
    localparam int OUT_DATA_W    = PATTERN_LEDS * COLOR_W;
    localparam int IN_DATA_W     = 8;

    localparam logic [BYTE_W-1:0] LEVEL_MAX = BYTE_W'(127);
    localparam logic [LVL_W-1:0]  LEVEL_TOP = {LEVEL_MAX, {FRACTION_BITS{1'b0}}};

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_START_A     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_B     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_START_C     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_END_A       = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_END_B       = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_END_C       = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = CFG_IDX_W'(6);

    typedef struct packed {
        logic load;   // push a freshly computed channel into the ring
        logic upd;    // push the stepped and clamped head channel
    } t_chan_ctl;

endpackage

[sv/lplf_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lplf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lplf_pkg::LVL_W-1:0]  i_dividend,
    input  logic [lplf_pkg::FC_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [lplf_pkg::LVL_W-1:0]  o_quot
);
    import lplf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FC_W-1:0]      r_rem;
    logic [LVL_W-1:0]     r_dvd;
    logic [FC_W-1:0]      r_dsr;

    logic [FC_W:0]        w_trial;
    logic [FC_W:0]        w_diff;
    logic                 w_qbit;

    assign w_trial = {r_rem, r_dvd[LVL_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_qbit  = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift the dividend out at the top, the quotient in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[FC_W-1:0] : w_trial[FC_W-1:0];
            r_dvd <= {r_dvd[LVL_W-2:0], w_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

[sv/lplf_chan.sv]
`timescale 1ns / 1ps

// Ring of channel levels and increments; the head is stepped one channel a cycle while upd is held.
module lplf_chan (
    input  logic                                        i_clk,
    input  lplf_pkg::t_chan_ctl                         i_ctl,
    input  logic [lplf_pkg::LVL_W-1:0]                  i_load_level,
    input  logic [lplf_pkg::INC_W-1:0]                  i_load_inc,
    output logic [lplf_pkg::CHANNELS-1:0][lplf_pkg::BYTE_W-1:0] o_levels
);
    import lplf_pkg::*;

    logic [LVL_W-1:0] r_lvl [CHANNELS];
    logic [INC_W-1:0] r_inc [CHANNELS];

    logic signed [SUM_W-1:0] w_sum;
    logic [LVL_W-1:0]        w_step;
    logic [LVL_W-1:0]        n_tail_lvl;
    logic [INC_W-1:0]        n_tail_inc;

    assign w_sum = $signed({2'b00, r_lvl[0]}) + $signed({r_inc[0][INC_W-1], r_inc[0]});

    always_comb begin
        priority if (w_sum < 0) begin
            w_step = '0;
        end else if (w_sum > $signed({2'b00, LEVEL_TOP})) begin
            w_step = LEVEL_TOP;
        end else begin
            w_step = w_sum[LVL_W-1:0];
        end
    end

    always_comb begin
        if (i_ctl.load) begin
            n_tail_lvl = i_load_level;
            n_tail_inc = i_load_inc;
        end else begin
            n_tail_lvl = w_step;
            n_tail_inc = r_inc[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.upd) begin
            for (int k = 0; k < CHANNELS - 1; k++) begin
                r_lvl[k] <= r_lvl[k+1];
                r_inc[k] <= r_inc[k+1];
            end
            r_lvl[CHANNELS-1] <= n_tail_lvl;
            r_inc[CHANNELS-1] <= n_tail_inc;
        end
    end

    // integer parts, valid while the ring is aligned
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            o_levels[k] = r_lvl[k][LVL_W-1:FRACTION_BITS];
        end
    end

endmodule

[sv/led_pattern_linear_fade_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// s (tick)  in         i_s_tvalid/o_s_tready  i_s_tdata[0] restart
// m (frame) out        o_m_tvalid/i_m_tready  o_m_tdata colours a,b,c; o_m_tlast last frame
// cfg       in         i_cfg_we               i_cfg_idx, i_cfg_wdata
//
// A restart tick runs each of the nine channels' increment through the bit-serial
// divider, 24 quotient bits one per cycle. A plain tick during a fade makes one ring step
// per channel after the frame is captured. A tick with no fade running is taken and
// dropped, and the tick side stays ready.
// Reset is synchronous and active low; it clears control state and loads the register
// defaults (colours 0, frame count 1). A waiting frame holds the output register; a
// new tick is still accepted and stalls only at its own capture point.
module led_pattern_linear_fade_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [lplf_pkg::IN_DATA_W-1:0]      i_s_tdata,   // [0] restart, rest zero
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lplf_pkg::OUT_DATA_W-1:0]     o_m_tdata,   // color_a, color_b, color_c
    output logic                                o_m_tlast,   // last_frame
    input  logic                                i_cfg_we,
    input  logic [lplf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lplf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import lplf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DSTART = 3'd1;
    localparam logic [2:0] S_DWAIT  = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_UPD    = 3'd4;

    localparam logic [CH_IDX_W-1:0] CH_LAST = CH_IDX_W'(CHANNELS - 1);

    // configuration registers
    logic [COLOR_W-1:0] r_start_a, r_start_b, r_start_c;
    logic [COLOR_W-1:0] r_end_a, r_end_b, r_end_c;
    logic [FC_W-1:0]    r_frame_count;

    // sequencer
    logic [2:0]          r_state;
    logic [CH_IDX_W-1:0] r_ch;
    logic [FC_W-1:0]     r_frames_left;
    logic                r_active;
    logic [FC_W-1:0]     r_fc;

    // start and end bytes, shifted out one channel at a time
    logic [OUT_DATA_W-1:0] r_s_sh;
    logic [OUT_DATA_W-1:0] r_e_sh;

    // output register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                  r_m_last;

    logic                  w_s_xfer;
    logic                  w_restart;
    logic                  w_capture;
    logic [BYTE_W-1:0]     w_s_byte;
    logic [BYTE_W-1:0]     w_e_byte;
    logic                  w_neg;
    logic [BYTE_W-1:0]     w_mag;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [LVL_W-1:0]      w_quot;
    logic [INC_W-1:0]      w_inc;
    logic [LVL_W-1:0]      w_load_level;
    t_chan_ctl             w_ctl;
    logic [CHANNELS-1:0][BYTE_W-1:0] w_levels;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_restart  = i_s_tdata[0];
    assign w_capture  = (r_state == S_EMIT) && (!r_m_valid || i_m_tready);

    // configuration writes; an index past the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_a     <= '0;
            r_start_b     <= '0;
            r_start_c     <= '0;
            r_end_a       <= '0;
            r_end_b       <= '0;
            r_end_c       <= '0;
            r_frame_count <= FC_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_A:     r_start_a     <= i_cfg_wdata;
                CFG_START_B:     r_start_b     <= i_cfg_wdata;
                CFG_START_C:     r_start_c     <= i_cfg_wdata;
                CFG_END_A:       r_end_a       <= i_cfg_wdata;
                CFG_END_B:       r_end_b       <= i_cfg_wdata;
                CFG_END_C:       r_end_c       <= i_cfg_wdata;
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_wdata[FC_W-1:0];
                default:         ;
            endcase
        end
    end

    // signed increment of the head channel: (|e - s| << frac) / fc, sign of e - s
    assign w_s_byte     = r_s_sh[BYTE_W-1:0];
    assign w_e_byte     = r_e_sh[BYTE_W-1:0];
    assign w_neg        = (w_e_byte < w_s_byte);
    assign w_mag        = w_neg ? (w_s_byte - w_e_byte) : (w_e_byte - w_s_byte);
    assign w_inc        = w_neg ? (INC_W'(0) - {1'b0, w_quot}) : {1'b0, w_quot};
    assign w_load_level = {w_s_byte, {FRACTION_BITS{1'b0}}};
    assign w_div_start  = (r_state == S_DSTART);

    assign w_ctl.load = (r_state == S_DWAIT) && w_div_done;
    assign w_ctl.upd  = (r_state == S_UPD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ch          <= '0;
            r_frames_left <= '0;
            r_active      <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_xfer) begin
                        if (w_restart) begin
                            // abandon any fade under way and arm a new one
                            r_frames_left <= (r_frame_count == '0) ? FC_W'(1) : r_frame_count;
                            r_active      <= 1'b1;
                            r_ch          <= '0;
                            r_state       <= S_DSTART;
                        end else if (r_active) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        if (r_ch == CH_LAST) begin
                            r_ch    <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_capture) begin
                        r_m_valid     <= 1'b1;
                        r_frames_left <= r_frames_left - 1'b1;
                        r_active      <= (r_frames_left != FC_W'(1));
                        r_ch          <= '0;
                        r_state       <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_ch == CH_LAST) begin
                        r_ch    <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // load the colour bytes on restart; drop the head byte once its channel is in the ring
    always_ff @(posedge i_clk) begin
        if (w_s_xfer && w_restart) begin
            r_s_sh <= {r_start_c, r_start_b, r_start_a};
            r_e_sh <= {r_end_c, r_end_b, r_end_a};
            r_fc   <= (r_frame_count == '0) ? FC_W'(1) : r_frame_count;
        end else if (w_ctl.load) begin
            r_s_sh <= {{BYTE_W{1'b0}}, r_s_sh[OUT_DATA_W-1:BYTE_W]};
            r_e_sh <= {{BYTE_W{1'b0}}, r_e_sh[OUT_DATA_W-1:BYTE_W]};
        end
    end

    // capture the frame before the levels are stepped
    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_m_data <= w_levels;
            r_m_last <= (r_frames_left == FC_W'(1));
        end
    end

    lplf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_mag, {FRACTION_BITS{1'b0}}}),
        .i_divisor  (r_fc),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    lplf_chan u_chan (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_load_level (w_load_level),
        .i_load_inc   (w_inc),
        .o_levels     (w_levels)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

endmodule

[sv/lplf_chk.sv]
`timescale 1ns / 1ps

module lplf_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic [lplf_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [lplf_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input logic                                o_m_tlast,
    input logic                                i_cfg_we,
    input logic [lplf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input logic [lplf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    // a stalled frame holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled frame changed");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("frame valid after reset");

    // a taken restart closes the tick side and raises no frame straight after it
    a_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tdata[0] |=> !o_s_tready && !$rose(o_m_tvalid))
        else $error("restart did not hold the tick side");

    // a new frame appears only while a tick is being worked on
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !o_s_tready)
        else $error("frame appeared while idle");

endmodule

bind led_pattern_linear_fade_core lplf_chk u_lplf_chk (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import lplf_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    // A restart computes nine divisions. Allow a margin on top of that before touching the
    // registers after the last frame has come out.
    localparam int SETTLE_CYCLES = 320;
    localparam int RANDOM_TICKS  = 1730;
    // Slowest correct run: every transfer a restart, each side idling for its longest gap
    // on every transfer, plus the settling pauses. Take that several times over.
    localparam longint CYCLE_LIMIT = 8_000_000;

    localparam int TICK_RESTART_BIT = 0;
    // the port has one index past the frame count register; the block ignores it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);

    typedef struct packed {
        bit restart;
        bit drain;      // hold this transfer until every pending frame has come out
    } t_tick_item;

    typedef struct packed {
        logic [COLOR_W-1:0] color_a;
        logic [COLOR_W-1:0] color_b;
        logic [COLOR_W-1:0] color_c;
        logic               last_frame;
    } t_frame;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;   // [0] restart, rest zero
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;          // color_a, color_b, color_c
    logic                  o_m_tlast;          // last_frame
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    led_pattern_linear_fade_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the fade engine: registers and per-channel state
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0]      start_colour [PATTERN_LEDS];
    logic [COLOR_W-1:0]      end_colour   [PATTERN_LEDS];
    logic [FC_W-1:0]         fade_frames  = FC_W'(1);
    logic [LVL_W-1:0]        level        [CHANNELS];
    logic signed [INC_W-1:0] step_inc     [CHANNELS];
    logic [FC_W-1:0]         frames_to_go = '0;
    bit                      fading       = 1'b0;

    t_tick_item tick_queue[$];
    t_frame     frame_expect[$];

    int     fail_count      = 0;
    int     ticks_taken     = 0;
    int     frames_checked  = 0;
    int     last_frames     = 0;
    int     restarts_taken  = 0;
    int     phases_run      = 0;
    longint cycle_count     = 0;
    bit     s_fire          = 1'b0;
    bit     no_idle         = 1'b0;
    int     send_gap        = 0;
    int     sink_stall      = 0;

    // generator-side count of queued ticks and the frame count last written
    int              ticks_queued   = 0;
    logic [FC_W-1:0] plan_frames    = FC_W'(1);

    initial begin
        for (int i = 0; i < PATTERN_LEDS; i++) begin
            start_colour[i] = '0;
            end_colour[i]   = '0;
        end
        for (int i = 0; i < CHANNELS; i++) begin
            level[i]    = '0;
            step_inc[i] = '0;
        end
    end

    // Apply one accepted tick to the shadow state; report the frame it emits, if any.
    function automatic void advance_fade(input bit restart, output bit emits,
                                         output t_frame frame);
        logic [FC_W-1:0]           divisor;
        logic [BYTE_W-1:0]         s_lvl;
        logic [BYTE_W-1:0]         e_lvl;
        logic [LVL_W-1:0]          span;
        logic [LVL_W-1:0]          quot;
        logic signed [SUM_W-1:0]   sum;
        logic [COLOR_W-1:0]        packed_led [3];
        int                        led;
        int                        ch;
        emits = 1'b0;
        frame = '0;
        if (restart) begin
            divisor = (fade_frames == '0) ? FC_W'(1) : fade_frames;
            for (int i = 0; i < CHANNELS; i++) begin
                led   = i / CH_PER_LED;
                ch    = i % CH_PER_LED;
                s_lvl = start_colour[led][BYTE_W*ch +: BYTE_W];
                e_lvl = end_colour[led][BYTE_W*ch +: BYTE_W];
                span  = {(e_lvl >= s_lvl) ? e_lvl - s_lvl : s_lvl - e_lvl,
                         {FRACTION_BITS{1'b0}}};
                quot  = span / LVL_W'(divisor);
                level[i]    = {s_lvl, {FRACTION_BITS{1'b0}}};
                step_inc[i] = (e_lvl >= s_lvl) ? $signed({1'b0, quot})
                                               : -$signed({1'b0, quot});
            end
            frames_to_go = divisor;
            fading       = 1'b1;
        end
        if (fading) begin
            for (int l = 0; l < 3; l++) begin
                packed_led[l] = '0;
                if (l < PATTERN_LEDS)
                    for (int c = 0; c < CH_PER_LED; c++)
                        packed_led[l][BYTE_W*c +: BYTE_W] =
                            level[l*CH_PER_LED + c][LVL_W-1 -: BYTE_W];
            end
            emits            = 1'b1;
            frame.color_a    = packed_led[0];
            frame.color_b    = packed_led[1];
            frame.color_c    = packed_led[2];
            frame.last_frame = (frames_to_go == FC_W'(1));
            // step and clamp every channel to 0..127 after the frame goes out
            for (int i = 0; i < CHANNELS; i++) begin
                sum = $signed({2'b00, level[i]}) + step_inc[i];
                if (sum > $signed({2'b00, LEVEL_TOP}))
                    sum = $signed({2'b00, LEVEL_TOP});
                if (sum < 0)
                    sum = '0;
                level[i] = sum[LVL_W-1:0];
            end
            frames_to_go = frames_to_go - 1'b1;
            if (frames_to_go == '0)
                fading = 1'b0;
        end
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 300);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_colour();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 24'h7f7f7f;
            3:       return 24'h808080;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // Frame count written with random junk above the 16-bit field.
    function automatic logic [CFG_DATA_W-1:0] pick_frames();
        logic [FC_W-1:0] fc;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            fc = FC_W'($urandom_range(1, 12));
        else if (r < 85)
            fc = FC_W'($urandom_range(13, 64));
        else if (r < 93)
            fc = FC_W'($urandom_range(0, 1));
        else if (r < 97)
            fc = FC_W'($urandom_range(65534, 65535));
        else
            fc = FC_W'($urandom_range(256, 1000));
        return {BYTE_W'($urandom), fc};
    endfunction

    // Queue a tick and keep count of the ticks queued.
    function automatic void queue_tick(input bit restart, input bit drain);
        t_tick_item it;
        it.restart = restart;
        it.drain   = drain;
        tick_queue.push_back(it);
        ticks_queued++;
    endfunction

    // One register write, mirrored into the shadow copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_START_A:     start_colour[0] = data;
            CFG_START_B:     start_colour[1] = data;
            CFG_START_C:     start_colour[2] = data;
            CFG_END_A:       end_colour[0]   = data;
            CFG_END_B:       end_colour[1]   = data;
            CFG_END_C:       end_colour[2]   = data;
            CFG_FRAME_COUNT: begin
                fade_frames = data[FC_W-1:0];
                plan_frames = data[FC_W-1:0];
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Let the queued ticks drain, every frame come out, and the engine go quiet.
    task automatic settle();
        while (tick_queue.size() != 0 || i_s_tvalid || frame_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tick driver: change at the falling edge, one assignment per signal
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_ticks
        logic                 nxt_valid;
        logic [IN_DATA_W-1:0] nxt_data;
        t_tick_item           it;
        nxt_valid = i_s_tvalid;
        nxt_data  = i_s_tdata;
        if (i_rst_n && (!i_s_tvalid || s_fire)) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (tick_queue.size() != 0 &&
                         !(tick_queue[0].drain && frame_expect.size() != 0)) begin
                it        = tick_queue.pop_front();
                nxt_valid = 1'b1;
                nxt_data  = '0;
                nxt_data[TICK_RESTART_BIT] = it.restart;
                send_gap  = pick_gap();
            end
        end
        i_s_tvalid <= nxt_valid;
        i_s_tdata  <= nxt_data;
    end

    // Frame sink: hold ready low for random stalls.
    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            i_m_tready <= 1'b0;
            sink_stall--;
        end else begin
            i_m_tready <= 1'b1;
            sink_stall = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Predict on each accepted tick, then check each accepted frame
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_frames
        bit     emits;
        t_frame want;
        t_frame got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d frames outstanding",
                     cycle_count, frame_expect.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            s_fire <= i_rst_n && i_s_tvalid && o_s_tready;
            if (i_rst_n && i_s_tvalid && o_s_tready) begin
                ticks_taken++;
                if (i_s_tdata[TICK_RESTART_BIT])
                    restarts_taken++;
                advance_fade(i_s_tdata[TICK_RESTART_BIT], emits, want);
                if (emits)
                    frame_expect.push_back(want);
            end
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.color_a    = o_m_tdata[0*COLOR_W +: COLOR_W];
                got.color_b    = o_m_tdata[1*COLOR_W +: COLOR_W];
                got.color_c    = o_m_tdata[2*COLOR_W +: COLOR_W];
                got.last_frame = o_m_tlast;
                if (frame_expect.size() == 0) begin
                    $error("unexpected frame: color_a %06h color_b %06h color_c %06h last %0b",
                           got.color_a, got.color_b, got.color_c, got.last_frame);
                    fail_count++;
                end else begin
                    want = frame_expect.pop_front();
                    frames_checked++;
                    if (got.last_frame)
                        last_frames++;
                    if (got.color_a !== want.color_a) begin
                        $error("color_a: expected %06h, got %06h", want.color_a, got.color_a);
                        fail_count++;
                    end
                    if (got.color_b !== want.color_b) begin
                        $error("color_b: expected %06h, got %06h", want.color_b, got.color_b);
                        fail_count++;
                    end
                    if (got.color_c !== want.color_c) begin
                        $error("color_c: expected %06h, got %06h", want.color_c, got.color_c);
                        fail_count++;
                    end
                    if (got.last_frame !== want.last_frame) begin
                        $error("last_frame: expected %0b, got %0b",
                               want.last_frame, got.last_frame);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed corners first, then random fades
    // ------------------------------------------------------------------
    initial begin : stimulus
        int goal;
        int phase_goal;
        int fc_eff;
        int n_ticks;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: colours 0, one frame; ticks with no fade are dropped
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        settle();

        // start above the clamp, full-scale rises and falls; zero frame count acts as one
        write_reg(CFG_START_A, 24'hffffff);
        write_reg(CFG_START_B, 24'h000000);
        write_reg(CFG_START_C, 24'h7f80ff);
        write_reg(CFG_END_A, 24'h000000);
        write_reg(CFG_END_B, 24'hffffff);
        write_reg(CFG_END_C, 24'h80017f);
        write_reg(CFG_FRAME_COUNT, 24'hff0000);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        settle();

        // short fade, abandoned half way by a restart sent only after the line drains
        write_reg(CFG_FRAME_COUNT, 24'h000004);
        write_reg(CFG_SPARE, COLOR_W'($urandom));
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        repeat (4) queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        settle();

        // longest fade: tiny increments, left running
        write_reg(CFG_FRAME_COUNT, 24'h00ffff);
        queue_tick(1'b1, 1'b0);
        repeat (3) queue_tick(1'b0, 1'b0);
        settle();

        // two-frame fade from black to white on the first LED
        write_reg(CFG_START_A, 24'h000000);
        write_reg(CFG_END_A, 24'hffffff);
        write_reg(CFG_FRAME_COUNT, 24'h000002);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        settle();
        phases_run = 5;

        goal = ticks_queued + RANDOM_TICKS;
        while (ticks_queued < goal) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) write_reg(CFG_START_A, pick_colour());
            if ($urandom_range(0, 9) < 7) write_reg(CFG_START_B, pick_colour());
            if ($urandom_range(0, 9) < 7) write_reg(CFG_START_C, pick_colour());
            if ($urandom_range(0, 9) < 7) write_reg(CFG_END_A, pick_colour());
            if ($urandom_range(0, 9) < 7) write_reg(CFG_END_B, pick_colour());
            if ($urandom_range(0, 9) < 7) write_reg(CFG_END_C, pick_colour());
            write_reg(CFG_FRAME_COUNT, pick_frames());
            if ($urandom_range(0, 15) == 0)
                write_reg(CFG_SPARE, COLOR_W'($urandom));

            phase_goal = ticks_queued + $urandom_range(30, 80);
            if (phase_goal > goal)
                phase_goal = goal;
            while (ticks_queued < phase_goal) begin
                if ($urandom_range(0, 99) < 80) begin
                    // a whole fade, sometimes cut short, sometimes overrun into idle ticks
                    fc_eff  = (plan_frames == '0) ? 1 : int'(plan_frames);
                    n_ticks = (fc_eff - 1 > 40) ? 40 : fc_eff - 1;
                    if ($urandom_range(0, 4) == 0)
                        n_ticks = $urandom_range(0, n_ticks);
                    queue_tick(1'b1, $urandom_range(0, 39) == 0);
                    repeat (n_ticks) queue_tick(1'b0, 1'b0);
                    repeat ($urandom_range(0, 2)) queue_tick(1'b0, 1'b0);
                end else begin
                    // stray ticks
                    repeat ($urandom_range(1, 4))
                        queue_tick($urandom_range(0, 3) == 0, 1'b0);
                end
            end
            settle();
            phases_run++;
        end

        $display("Covered %0d ticks (%0d restarts) over %0d register settings",
                 ticks_taken, restarts_taken, phases_run);
        $display("Checked %0d frames, %0d of them closing a fade; %0d mismatches",
                 frames_checked, last_frames, fail_count);
        if (fail_count == 0 && frame_expect.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
